// ===== design/cpmg_tcc_pkg.sv =====
// Shared constants and register indexes for the CPMG timing count calculator.
package cpmg_tcc_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 12;

  localparam int TIME_W  = 24;  // Q12.12 time fields; count fields are 24-bit integers
  localparam int FREQ_W  = 22;  // Q10.12 frequency registers
  localparam int SAMP_W  = 16;
  localparam int IDX_W   = 3;
  localparam int LANES   = 5;   // p90, d90, p180, d180, capture

  localparam logic [IDX_W-1:0] REG_SEQ_CLK = 3'd0;
  localparam logic [IDX_W-1:0] REG_RF_FREQ = 3'd1;
  localparam logic [IDX_W-1:0] REG_ADC     = 3'd2;
  localparam logic [IDX_W-1:0] REG_SHIFT   = 3'd3;
  localparam logic [IDX_W-1:0] REG_SAMPLES = 3'd4;

  localparam logic [FREQ_W-1:0] SEQ_CLK_RST = 22'd4096000;
  localparam logic [FREQ_W-1:0] RF_FREQ_RST = 22'd163840;
  localparam logic [FREQ_W-1:0] ADC_RST     = 22'd102400;
  localparam logic [SAMP_W-1:0] SAMPLES_RST = 16'd64;

endpackage

// ===== design/cpmg_tcc_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module cpmg_tcc_div #(
  parameter int W = 27
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W:0]    trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[W-1]};
    if (start) begin
      cnt_nxt = CW'(W);
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      if (cnt_r == CW'(1)) done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/cpmg_timing_count_calculator.sv =====
// Top level: CPMG pulse, delay and capture counts from microsecond timings.
// An accepted start beat passes through the registered stages of the item pipeline to the out_valid strobe.
// Throughput: one item per cycle while busy is low; results cannot be held off by the receiver.
// After reset and after a write to a frequency register the ratio and its
// reciprocal are recomputed by two iterative dividers; busy is high and
// cfg_ready low meanwhile. Reset loads the register defaults.
module cpmg_timing_count_calculator #(
  parameter int COUNT_BITS = cpmg_tcc_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = cpmg_tcc_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // item channel
  input  logic        start,
  output logic        busy,
  input  logic [23:0] in_pulse90_us,
  input  logic [23:0] in_pulse180_us,
  input  logic [23:0] in_echo_time_us,
  // result channel
  output logic        out_valid,
  output logic [23:0] out_pulse90_count,
  output logic [23:0] out_delay90_count,
  output logic [23:0] out_pulse180_count,
  output logic [23:0] out_delay180_count,
  output logic [23:0] out_capture_delay_count,
  output logic        out_range_error,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int S   = 2 * FRAC_BITS;          // product scale
  localparam int PW  = 46;                     // time x frequency
  localparam int XW  = 48 - S;                 // pre-rounding counts
  localparam int MW  = 22;                     // ratio width
  localparam int NW  = ((XW > MW) ? XW : MW) + 2;  // 2x+m
  localparam int K   = NW;                     // reciprocal scale
  localparam int DW  = MW + 1;                 // divisor 2m
  localparam int DVW = K + 1;
  localparam int TW  = 27;                     // capture time sum
  localparam int CVW = 50;                     // capture product
  localparam int L   = cpmg_tcc_pkg::LANES;
  localparam logic [63:0] MAXV = 64'((65'd1 << COUNT_BITS) - 65'd1);
  localparam logic signed [CVW-1:0] NEG_LIM = -(CVW'(1) <<< (S + 1));

  // sequencer codes
  localparam logic [1:0] SEQ_IDLE  = 2'd0;
  localparam logic [1:0] SEQ_RATIO = 2'd1;
  localparam logic [1:0] SEQ_RECIP = 2'd2;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [21:0] clk_mhz_r, rf_mhz_r, adc_mhz_r;
  logic [23:0] shift_r;
  logic [15:0] samples_r;
  logic        cfg_beat;

  assign cfg_beat = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_mhz_r <= cpmg_tcc_pkg::SEQ_CLK_RST;
      rf_mhz_r  <= cpmg_tcc_pkg::RF_FREQ_RST;
      adc_mhz_r <= cpmg_tcc_pkg::ADC_RST;
      shift_r   <= '0;
      samples_r <= cpmg_tcc_pkg::SAMPLES_RST;
    end else if (cfg_beat) begin
      case (cfg_index)
        cpmg_tcc_pkg::REG_SEQ_CLK: clk_mhz_r <= cfg_data[21:0];
        cpmg_tcc_pkg::REG_RF_FREQ: rf_mhz_r  <= cfg_data[21:0];
        cpmg_tcc_pkg::REG_ADC:     adc_mhz_r <= cfg_data[21:0];
        cpmg_tcc_pkg::REG_SHIFT:   shift_r   <= cfg_data;
        cpmg_tcc_pkg::REG_SAMPLES: samples_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Ratio sequencer: round(clk/f), then floor(2^K / 2m) for each ratio
  // ---------------------------------------------------------------------
  logic [1:0]     seq_r, seq_nxt;
  logic           go_r, go_nxt;
  logic [MW-1:0]  rf_m_r, rf_m_nxt, adc_m_r, adc_m_nxt;
  logic [K-1:0]   rf_rcp_r, rf_rcp_nxt, adc_rcp_r, adc_rcp_nxt;
  logic           ratio_err_r, ratio_err_nxt;
  logic [DVW-1:0] rf_dvd, rf_dvs, adc_dvd, adc_dvs;
  logic [DVW-1:0] rf_quo, adc_quo;
  logic           rf_done, adc_done;
  logic           freq_write;

  assign freq_write = cfg_beat && (cfg_index == cpmg_tcc_pkg::REG_SEQ_CLK ||
                                   cfg_index == cpmg_tcc_pkg::REG_RF_FREQ ||
                                   cfg_index == cpmg_tcc_pkg::REG_ADC);

  always_comb begin
    if (seq_r == SEQ_RECIP) begin
      rf_dvd  = DVW'(1) << K;
      adc_dvd = DVW'(1) << K;
      rf_dvs  = DVW'({rf_m_r, 1'b0});
      adc_dvs = DVW'({adc_m_r, 1'b0});
    end else begin
      rf_dvd  = DVW'({clk_mhz_r, 1'b0}) + DVW'(rf_mhz_r);
      adc_dvd = DVW'({clk_mhz_r, 1'b0}) + DVW'(adc_mhz_r);
      rf_dvs  = DVW'({rf_mhz_r, 1'b0});
      adc_dvs = DVW'({adc_mhz_r, 1'b0});
    end
  end

  cpmg_tcc_div #(.W(DVW)) u_div_rf (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go_r),
    .dividend (rf_dvd),
    .divisor  (rf_dvs),
    .done     (rf_done),
    .quotient (rf_quo)
  );

  cpmg_tcc_div #(.W(DVW)) u_div_adc (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go_r),
    .dividend (adc_dvd),
    .divisor  (adc_dvs),
    .done     (adc_done),
    .quotient (adc_quo)
  );

  always_comb begin
    seq_nxt       = seq_r;
    go_nxt        = 1'b0;
    rf_m_nxt      = rf_m_r;
    adc_m_nxt     = adc_m_r;
    rf_rcp_nxt    = rf_rcp_r;
    adc_rcp_nxt   = adc_rcp_r;
    ratio_err_nxt = ratio_err_r;
    case (seq_r)
      SEQ_IDLE: begin
        if (freq_write) begin
          seq_nxt = SEQ_RATIO;
          go_nxt  = 1'b1;
        end
      end
      SEQ_RATIO: begin
        if (rf_done && adc_done) begin
          ratio_err_nxt = 1'b0;
          rf_m_nxt  = rf_quo[MW-1:0];
          adc_m_nxt = adc_quo[MW-1:0];
          // zero frequency or zero ratio: fall back to a ratio of one
          if (rf_mhz_r == '0 || rf_quo == '0) begin
            rf_m_nxt      = MW'(1);
            ratio_err_nxt = 1'b1;
          end
          if (adc_mhz_r == '0 || adc_quo == '0) begin
            adc_m_nxt     = MW'(1);
            ratio_err_nxt = 1'b1;
          end
          seq_nxt = SEQ_RECIP;
          go_nxt  = 1'b1;
        end
      end
      SEQ_RECIP: begin
        if (rf_done && adc_done) begin
          rf_rcp_nxt  = rf_quo[K-1:0];
          adc_rcp_nxt = adc_quo[K-1:0];
          seq_nxt     = SEQ_IDLE;
        end
      end
      default: seq_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= SEQ_RATIO;
      go_r        <= 1'b1;
      ratio_err_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      go_r        <= go_nxt;
      ratio_err_r <= ratio_err_nxt;
    end
    rf_m_r    <= rf_m_nxt;
    adc_m_r   <= adc_m_nxt;
    rf_rcp_r  <= rf_rcp_nxt;
    adc_rcp_r <= adc_rcp_nxt;
  end

  assign busy      = (seq_r != SEQ_IDLE);
  assign cfg_ready = (seq_r == SEQ_IDLE);

  // ---------------------------------------------------------------------
  // Item pipeline
  // ---------------------------------------------------------------------
  logic accept;
  assign accept = start && !busy;

  // Stage 1: time x clock products, capture time sum in 2^-(F+1) us
  logic                  v1_r;
  logic [PW-1:0]         pc90_r, pc180_r, pe_r;
  logic signed [TW-1:0]  tsum_r, tsum_nxt;

  always_comb begin
    tsum_nxt = $signed(TW'(in_echo_time_us))
             + $signed({{2{shift_r[23]}}, shift_r, 1'b0})
             - $signed({2'b00, in_pulse180_us, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= accept;
    pc90_r  <= PW'(in_pulse90_us * clk_mhz_r);
    pc180_r <= PW'(in_pulse180_us * clk_mhz_r);
    pe_r    <= PW'(in_echo_time_us * clk_mhz_r);
    tsum_r  <= tsum_nxt;
  end

  // Stage 2: rounding to clocks, delay differences, capture product
  logic                  v2_r;
  logic [XW-1:0]         c90_r, c180_r, d90_r, d180_r;
  logic [XW-1:0]         c90_nxt, c180_nxt, d90_nxt, d180_nxt, half_e, full_e;
  logic                  err2_r, err2_nxt;
  logic signed [CVW-1:0] capv_r;
  logic [PW:0]           r90, r180, rhalf, rfull;

  always_comb begin
    r90      = {1'b0, pc90_r}  + ((PW+1)'(1) << (S - 1));
    r180     = {1'b0, pc180_r} + ((PW+1)'(1) << (S - 1));
    rfull    = {1'b0, pe_r}    + ((PW+1)'(1) << (S - 1));
    rhalf    = {1'b0, pe_r}    + ((PW+1)'(1) << S);
    c90_nxt  = XW'(r90 >> S);
    c180_nxt = XW'(r180 >> S);
    full_e   = XW'(rfull >> S);
    half_e   = XW'(rhalf >> (S + 1));
    err2_nxt = 1'b0;
    if (half_e >= c90_nxt) begin
      d90_nxt = half_e - c90_nxt;
    end else begin
      d90_nxt  = '0;
      err2_nxt = 1'b1;
    end
    if (full_e >= c180_nxt) begin
      d180_nxt = full_e - c180_nxt;
    end else begin
      d180_nxt = '0;
      err2_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    c90_r  <= c90_nxt;
    c180_r <= c180_nxt;
    d90_r  <= d90_nxt;
    d180_r <= d180_nxt;
    err2_r <= err2_nxt;
    capv_r <= CVW'(tsum_r * $signed({1'b0, adc_mhz_r}));
  end

  // Stage 3: capture delay truncation, dividends 2x+m per lane
  logic                  v3_r;
  logic [NW-1:0]         n3_r [L];
  logic [NW-1:0]         n3_nxt [L];
  logic                  err3_r, err3_nxt;
  logic signed [CVW-1:0] capw;
  logic [XW-1:0]         cap;
  logic [XW-1:0]         xl [L];
  logic [MW-1:0]         ml [L];

  always_comb begin
    capw     = capv_r - $signed(CVW'(samples_r) << S);
    err3_nxt = err2_r;
    if (!capw[CVW-1]) begin
      cap = XW'(capw >>> (S + 1));
    end else begin
      cap = '0;
      // a value in (-1, 0) truncates to zero without a flag
      if (capw <= NEG_LIM) err3_nxt = 1'b1;
    end
    xl[0] = c90_r;
    xl[1] = d90_r;
    xl[2] = c180_r;
    xl[3] = d180_r;
    xl[4] = cap;
    for (int i = 0; i < L; i++) begin
      ml[i]     = (i == L - 1) ? adc_m_r : rf_m_r;
      n3_nxt[i] = NW'({xl[i], 1'b0}) + NW'(ml[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    n3_r   <= n3_nxt;
    err3_r <= err3_nxt;
  end

  // Stage 4: quotient estimate from the reciprocal
  logic            v4_r;
  logic [NW-1:0]   n4_r [L];
  logic [NW-1:0]   q4_r [L];
  logic [NW-1:0]   q4_nxt [L];
  logic [2*NW-1:0] prod4 [L];
  logic            err4_r;

  always_comb begin
    for (int i = 0; i < L; i++) begin
      // full-width product, then drop the reciprocal scale
      prod4[i]  = n3_r[i] * ((i == L - 1) ? adc_rcp_r : rf_rcp_r);
      q4_nxt[i] = NW'(prod4[i] >> K);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    n4_r   <= n3_r;
    q4_r   <= q4_nxt;
    err4_r <= err3_r;
  end

  // Stage 5: estimate times divisor (never above the dividend)
  logic          v5_r;
  logic [NW-1:0] n5_r [L];
  logic [NW-1:0] qd5_r [L];
  logic [NW-1:0] qd5_nxt [L];
  logic          err5_r;
  logic [DW-1:0] dl [L];

  always_comb begin
    for (int i = 0; i < L; i++) begin
      dl[i]      = {((i == L - 1) ? adc_m_r : rf_m_r), 1'b0};
      qd5_nxt[i] = NW'(q4_r[i] * dl[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
    n5_r   <= n4_r;
    qd5_r  <= qd5_nxt;
    err5_r <= err4_r;
  end

  // Stage 6: one correction step, halve to q*m, saturate
  logic          v6_r;
  logic [23:0]   o6_r [L];
  logic [23:0]   o6_nxt [L];
  logic          err6_r, err6_nxt;
  logic [NW-1:0] rem6 [L];
  logic [NW-1:0] qd6 [L];
  logic [63:0]   mul6 [L];

  always_comb begin
    err6_nxt = err5_r | ratio_err_r;
    for (int i = 0; i < L; i++) begin
      rem6[i] = n5_r[i] - qd5_r[i];
      qd6[i]  = (rem6[i] >= NW'(dl[i])) ? qd5_r[i] + NW'(dl[i]) : qd5_r[i];
      mul6[i] = 64'(qd6[i] >> 1);
      if (mul6[i] > MAXV) begin
        mul6[i]  = MAXV;
        err6_nxt = 1'b1;
      end
      o6_nxt[i] = mul6[i][23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else        v6_r <= v5_r;
    o6_r   <= o6_nxt;
    err6_r <= err6_nxt;
  end

  assign out_valid               = v6_r;
  assign out_pulse90_count       = o6_r[0];
  assign out_delay90_count       = o6_r[1];
  assign out_pulse180_count      = o6_r[2];
  assign out_delay180_count      = o6_r[3];
  assign out_capture_delay_count = o6_r[4];
  assign out_range_error         = err6_r;

endmodule
